FILE: design/ffa_pkg.sv
`default_nettype none

package ffa_pkg;

    // Heap geometry
    localparam int HEAP_GRANULES   = 8192;
    localparam int GRAN_W          = $clog2(HEAP_GRANULES);
    localparam int ALIGN_BYTES     = 8;
    localparam int ALIGN_SHIFT     = $clog2(ALIGN_BYTES);
    localparam int HEADER_BYTES    = 8;
    localparam int MIN_CHUNK_BYTES = 16;

    // Field widths
    localparam int SIZE_W  = 17;          // chunk size in bytes, busy flag kept apart
    localparam int LINK_W  = GRAN_W + 1;  // valid flag + granule
    localparam int STEP_W  = GRAN_W + 1;  // holds HEAP_GRANULES itself
    localparam int CNT_W   = 13;
    localparam int REQ_W   = 16;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 80;

    localparam logic [SIZE_W-1:0] HEAP_CAP         = SIZE_W'(HEAP_GRANULES * ALIGN_BYTES);
    localparam logic [SIZE_W-1:0] RESET_HEAP_BYTES = SIZE_W'(65536);

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REPORT = 2'd2,
        OP_INIT   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_NOT_BUSY = 2'd3
    } status_t;

    typedef struct packed {
        logic    load;
        logic    clr_step;
        logic    clr_finish;
        logic    a_read;
        logic    a_advance;
        logic    a_split;
        logic    a_take;
        logic    f_read;
        logic    f_push;
        logic    r_read;
        logic    r_accum;
        logic    set_status;
        status_t status;
        logic    post;
    } ffa_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic a_end;
        logic a_fit;
        logic a_exact;
        logic f_outside;
        logic f_busy;
        logic r_end;
        logic r_zero;
        logic r_last;
        logic out_free;
    } ffa_stat_t;

    // Heap size in use: capped at the store and rounded down to a granule
    function automatic logic [SIZE_W-1:0] eff_bytes(input logic [SIZE_W-1:0] hb);
        logic [SIZE_W-1:0] b;
        b = (hb < HEAP_CAP) ? hb : HEAP_CAP;
        return b & ~SIZE_W'(ALIGN_BYTES - 1);
    endfunction

endpackage

`default_nettype wire

FILE: design/ffa_datapath.sv
`default_nettype none

module ffa_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ffa_pkg::ffa_cmd_t                   cmd,
    output ffa_pkg::ffa_stat_t                       stat,
    input  wire logic                                cfg_we,
    input  wire logic [ffa_pkg::SIZE_W-1:0]          cfg_wdata,
    input  wire logic [ffa_pkg::REQ_W-1:0]           request_bytes,
    input  wire logic [ffa_pkg::GRAN_W-1:0]          chunk_index,
    input  wire logic                                m_tready,
    output logic                                     m_tvalid,
    output logic [ffa_pkg::OUT_TDATA_W-1:0]          m_tdata
);

    localparam int SW = ffa_pkg::SIZE_W;
    localparam int GW = ffa_pkg::GRAN_W;
    localparam int LW = ffa_pkg::LINK_W;
    localparam int TW = ffa_pkg::STEP_W;
    localparam int CW = ffa_pkg::CNT_W;
    localparam int AS = ffa_pkg::ALIGN_SHIFT;
    localparam int OW = ffa_pkg::OUT_TDATA_W;
    localparam int HG = ffa_pkg::HEAP_GRANULES;

    // Chunk headers: busy flag on top of the size; free-list links
    logic [SW:0]   size_mem [HG];
    logic [LW-1:0] next_mem [HG];

    logic [SW-1:0]  heap_bytes_reg;
    logic [SW-1:0]  rebuild_reg;
    logic [GW-1:0]  clr_cnt_reg;
    logic           head_valid_reg, head_valid_next;
    logic [GW-1:0]  head_gran_reg, head_gran_next;

    logic [SW-1:0]  need_reg;
    logic [GW-1:0]  idx_reg;
    logic           link_valid_reg;
    logic [GW-1:0]  link_gran_reg;
    logic [GW-1:0]  prev_reg;
    logic           have_prev_reg;
    logic [TW-1:0]  steps_reg;
    logic [TW-1:0]  walk_p_reg;

    logic [SW:0]    rd_size_reg;
    logic [LW-1:0]  rd_next_reg;

    logic [GW-1:0]            res_index_reg;
    ffa_pkg::status_t         status_reg;
    logic [CW-1:0]            bc_reg, fc_reg;
    logic [SW-1:0]            bt_reg, ft_reg;
    logic                     m_tvalid_reg;
    logic [OW-1:0]            m_tdata_reg;

    logic [SW-1:0]  eff;
    logic [TW-1:0]  end_g;
    logic [SW-1:0]  need_sum;
    logic [SW-1:0]  need_calc;
    logic [SW-1:0]  rd_sz;
    logic [TW-1:0]  g;
    logic [GW-1:0]  q;
    logic [LW-1:0]  rest;
    logic           exact;
    logic [SW:0]    bt_sum, ft_sum;

    logic           rd_en;
    logic [GW-1:0]  rd_addr;
    logic           size_we, next_we;
    logic [GW-1:0]  size_wa, next_wa;
    logic [SW:0]    size_wd;
    logic [LW-1:0]  next_wd;

    assign eff       = ffa_pkg::eff_bytes(heap_bytes_reg);
    assign end_g     = TW'(eff >> AS);
    assign need_sum  = SW'(request_bytes)
                     + SW'(ffa_pkg::HEADER_BYTES + ffa_pkg::ALIGN_BYTES - 1);
    assign need_calc = need_sum & ~SW'(ffa_pkg::ALIGN_BYTES - 1);
    assign rd_sz     = rd_size_reg[SW-1:0];
    assign g         = TW'(rd_sz >> AS);
    assign q         = link_gran_reg + GW'(need_reg >> AS);
    assign exact     = (rd_sz == need_reg);
    assign rest      = exact ? rd_next_reg : {1'b1, q};
    assign bt_sum    = {1'b0, bt_reg} + {1'b0, rd_sz};
    assign ft_sum    = {1'b0, ft_reg} + {1'b0, rd_sz};

    // Status to the controller
    always_comb
    begin
        stat.clr_last  = (clr_cnt_reg == GW'(HG - 1));
        stat.a_end     = !link_valid_reg || (steps_reg >= TW'(HG));
        stat.a_exact   = exact;
        stat.a_fit     = exact || ({1'b0, rd_sz} >= ({1'b0, need_reg}
                                    + (SW+1)'(ffa_pkg::MIN_CHUNK_BYTES)));
        stat.f_outside = ((SW'(idx_reg) << AS) >= eff);
        stat.f_busy    = rd_size_reg[SW];
        stat.r_end     = !((walk_p_reg < end_g) && (walk_p_reg < TW'(HG))
                           && (steps_reg < TW'(HG)));
        stat.r_zero    = (g == '0);
        stat.r_last    = (g >= (end_g - walk_p_reg));
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

    // Read port
    always_comb
    begin
        rd_en   = cmd.a_read || cmd.f_read || cmd.r_read;
        rd_addr = link_gran_reg;
        if (cmd.f_read)
        begin
            rd_addr = idx_reg;
        end
        else if (cmd.r_read)
        begin
            rd_addr = walk_p_reg[GW-1:0];
        end
    end

    // Write ports and list head update
    always_comb
    begin
        size_we         = 1'b0;
        size_wa         = clr_cnt_reg;
        size_wd         = '0;
        next_we         = 1'b0;
        next_wa         = clr_cnt_reg;
        next_wd         = '0;
        head_valid_next = head_valid_reg;
        head_gran_next  = head_gran_reg;
        if (cmd.clr_step)
        begin
            size_we = 1'b1;
            next_we = 1'b1;
        end
        if (cmd.clr_finish)
        begin
            size_we         = 1'b1;
            size_wa         = '0;
            size_wd         = {1'b0, rebuild_reg};
            head_valid_next = (rebuild_reg != '0);
            head_gran_next  = '0;
        end
        if (cmd.a_split)
        begin
            size_we = 1'b1;
            size_wa = q;
            size_wd = {1'b0, rd_sz - need_reg};
            next_we = 1'b1;
            next_wa = q;
            next_wd = rd_next_reg;
        end
        if (cmd.a_take)
        begin
            size_we = 1'b1;
            size_wa = link_gran_reg;
            size_wd = {1'b1, need_reg};
            if (have_prev_reg)
            begin
                next_we = 1'b1;
                next_wa = prev_reg;
                next_wd = rest;
            end
            else
            begin
                head_valid_next = rest[LW-1];
                head_gran_next  = rest[GW-1:0];
            end
        end
        if (cmd.f_push)
        begin
            size_we         = 1'b1;
            size_wa         = idx_reg;
            size_wd         = {1'b0, rd_sz};
            next_we         = 1'b1;
            next_wa         = idx_reg;
            next_wd         = {head_valid_reg, head_gran_reg};
            head_valid_next = 1'b1;
            head_gran_next  = idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (rd_en)
        begin
            rd_size_reg <= size_mem[rd_addr];
            rd_next_reg <= next_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_bytes_reg <= ffa_pkg::RESET_HEAP_BYTES;
            rebuild_reg    <= ffa_pkg::eff_bytes(ffa_pkg::RESET_HEAP_BYTES);
            clr_cnt_reg    <= '0;
            head_valid_reg <= 1'b0;
            head_gran_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                heap_bytes_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                rebuild_reg <= eff;
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            head_valid_reg <= head_valid_next;
            head_gran_reg  <= head_gran_next;
            if (cmd.post)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            need_reg       <= need_calc;
            idx_reg        <= chunk_index;
            link_valid_reg <= head_valid_reg;
            link_gran_reg  <= head_gran_reg;
            have_prev_reg  <= 1'b0;
            steps_reg      <= '0;
            walk_p_reg     <= '0;
            res_index_reg  <= '0;
            status_reg     <= ffa_pkg::ST_OK;
            bc_reg         <= '0;
            bt_reg         <= '0;
            fc_reg         <= '0;
            ft_reg         <= '0;
        end
        if (cmd.a_advance)
        begin
            prev_reg       <= link_gran_reg;
            have_prev_reg  <= 1'b1;
            link_valid_reg <= rd_next_reg[LW-1];
            link_gran_reg  <= rd_next_reg[GW-1:0];
            steps_reg      <= steps_reg + 1'b1;
        end
        if (cmd.a_take)
        begin
            res_index_reg <= link_gran_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.r_accum)
        begin
            if (rd_size_reg[SW])
            begin
                bc_reg <= (&bc_reg) ? bc_reg : bc_reg + 1'b1;
                bt_reg <= bt_sum[SW] ? '1 : bt_sum[SW-1:0];
            end
            else
            begin
                fc_reg <= (&fc_reg) ? fc_reg : fc_reg + 1'b1;
                ft_reg <= ft_sum[SW] ? '1 : ft_sum[SW-1:0];
            end
            walk_p_reg <= walk_p_reg + g;
            steps_reg  <= steps_reg + 1'b1;
        end
        if (cmd.post)
        begin
            m_tdata_reg <= OW'({ft_reg, fc_reg, bt_reg, bc_reg, status_reg, res_index_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |-> stat.out_free)
        else $error("result posted over an untaken result");

    a_post_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.post |=> m_tvalid_reg)
        else $error("posted result not presented");

    a_take_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.a_take |-> stat.a_fit)
        else $error("allocation took a chunk that does not fit");

    a_free_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.f_push |-> rd_size_reg[SW])
        else $error("free pushed a chunk that was not busy");

endmodule

`default_nettype wire

FILE: design/ffa_ctrl.sv
`default_nettype none

module ffa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [1:0]         opcode,
    input  wire ffa_pkg::ffa_stat_t stat,
    output ffa_pkg::ffa_cmd_t       cmd
);

    typedef enum logic [11:0] {
        S_CLEAR    = 12'b0000_0000_0001,
        S_CLR_LAST = 12'b0000_0000_0010,
        S_IDLE     = 12'b0000_0000_0100,
        S_A_LOOK   = 12'b0000_0000_1000,
        S_A_CHECK  = 12'b0000_0001_0000,
        S_A_SPLIT  = 12'b0000_0010_0000,
        S_A_TAKE   = 12'b0000_0100_0000,
        S_F_LOOK   = 12'b0000_1000_0000,
        S_F_CHECK  = 12'b0001_0000_0000,
        S_R_LOOK   = 12'b0010_0000_0000,
        S_R_CHECK  = 12'b0100_0000_0000,
        S_POST     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_CLR_LAST;
                end
            end
            S_CLR_LAST:
            begin
                cmd.clr_finish = 1'b1;
                pend_next      = 1'b0;
                state_next     = pend_reg ? S_POST : S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    case (ffa_pkg::opcode_t'(opcode))
                        ffa_pkg::OP_ALLOC:  state_next = S_A_LOOK;
                        ffa_pkg::OP_FREE:   state_next = S_F_LOOK;
                        ffa_pkg::OP_REPORT: state_next = S_R_LOOK;
                        ffa_pkg::OP_INIT:
                        begin
                            pend_next  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:            state_next = S_POST;
                    endcase
                end
            end
            S_A_LOOK:
            begin
                if (stat.a_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ffa_pkg::ST_OOM;
                    state_next     = S_POST;
                end
                else
                begin
                    cmd.a_read = 1'b1;
                    state_next = S_A_CHECK;
                end
            end
            S_A_CHECK:
            begin
                if (!stat.a_fit)
                begin
                    cmd.a_advance = 1'b1;
                    state_next    = S_A_LOOK;
                end
                else
                begin
                    state_next = stat.a_exact ? S_A_TAKE : S_A_SPLIT;
                end
            end
            S_A_SPLIT:
            begin
                cmd.a_split = 1'b1;
                state_next  = S_A_TAKE;
            end
            S_A_TAKE:
            begin
                cmd.a_take = 1'b1;
                state_next = S_POST;
            end
            S_F_LOOK:
            begin
                if (stat.f_outside)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ffa_pkg::ST_OUTSIDE;
                    state_next     = S_POST;
                end
                else
                begin
                    cmd.f_read = 1'b1;
                    state_next = S_F_CHECK;
                end
            end
            S_F_CHECK:
            begin
                if (stat.f_busy)
                begin
                    cmd.f_push = 1'b1;
                end
                else
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ffa_pkg::ST_NOT_BUSY;
                end
                state_next = S_POST;
            end
            S_R_LOOK:
            begin
                if (stat.r_end)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    cmd.r_read = 1'b1;
                    state_next = S_R_CHECK;
                end
            end
            S_R_CHECK:
            begin
                if (stat.r_zero)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    cmd.r_accum = 1'b1;
                    state_next  = stat.r_last ? S_POST : S_R_LOOK;
                end
            end
            S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while one is in work");

endmodule

`default_nettype wire

FILE: design/first_fit_free_list_allocator.sv
`default_nettype none

// First-fit free-list heap allocator. Each item on the s_ channel carries one
// command in s_tuser (alloc, free, report, init) and yields exactly one result
// item on the m_ channel. Items are handled one at a time: alloc walks the free
// list node by node, report walks the heap chunk by chunk and free reads the
// header of one chunk, all through the single read port that the chunk-header
// memories share. After reset, and after every init, a clearing pass sweeps
// the header memories one entry per cycle and then builds the single free
// chunk; no item is accepted during it. Result items wait in an output
// register, so the next command can start while a result waits to be taken;
// a later result that finds the register still occupied holds the controller
// until the waiting one drains. The heap size register is written through
// cfg_we / cfg_wdata and takes effect at the next init; free range checks and
// report walks use its current value.
module first_fit_free_list_allocator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Command items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // request_bytes [15:0], chunk_index [28:16]
    input  wire logic [ffa_pkg::IN_TDATA_W-1:0]      s_tdata,
    // opcode [1:0]
    input  wire logic [1:0]                          s_tuser,
    // Result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // result_index [12:0], status [14:13], busy_chunks [27:15],
    // busy_total [44:28], free_chunks [57:45], free_total [74:58]
    output logic [ffa_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // Heap size register
    input  wire logic                                cfg_we,
    input  wire logic [ffa_pkg::SIZE_W-1:0]          cfg_wdata
);

    ffa_pkg::ffa_cmd_t  cmd;
    ffa_pkg::ffa_stat_t stat;

    // Sequencing: walks, clearing pass and result hand-off
    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Header memories, walk registers, counters and the output register
    ffa_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .request_bytes (s_tdata[15:0]),
        .chunk_index   (s_tdata[28:16]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .m_tdata       (m_tdata)
    );

endmodule

`default_nettype wire
